[rtl/stir_pkg.sv]
// ----------------------------------------------------------------------------
// stir_pkg
// Shared types, sizes and codes for the sorted table insert/remove core.
// ----------------------------------------------------------------------------
package stir_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OCNT_W   = 5;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [OCNT_W-1:0]       out_cnt_t;
  typedef logic [1:0]              status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
  } ctl_t;

endpackage

[rtl/sorted_table_insert_remove_core.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_core
// Result beat: the command is latched when taken, and the update pass in the
// EXEC state registers the result. A new command is taken only after the single
// update pass of the compare-and-shift cell row; a held result stalls that pass.
// Reset: entry count cleared to zero, no beat pending; entries need no clear.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  stir_pkg::value_t   in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output stir_pkg::status_t  out_status,
  output stir_pkg::out_cnt_t out_count,
  output stir_pkg::value_t   out_head_value
);
  import stir_pkg::*;

  ctl_t ctl;

  stir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  stir_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_head_value (out_head_value)
  );

endmodule

[rtl/stir_ctrl.sv]
// ----------------------------------------------------------------------------
// stir_ctrl
// Handshake controller: takes one command, runs one update pass in the
// datapath, and holds the result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module stir_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output stir_pkg::ctl_t ctl
);
  import stir_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic exec;

  assign in_ready = (state_r == S_IDLE);
  assign exec     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign ctl.load_in = in_valid && in_ready;
  assign ctl.exec    = exec;

endmodule

[rtl/stir_datapath.sv]
// ----------------------------------------------------------------------------
// stir_datapath
// Row of compare-and-shift cells holding the sorted entries, the entry
// count, the latched command and the result registers.
// ----------------------------------------------------------------------------
module stir_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  stir_pkg::ctl_t     ctl,
  input  logic               in_cmd,
  input  stir_pkg::value_t   in_value,
  output stir_pkg::status_t  out_status,
  output stir_pkg::out_cnt_t out_count,
  output stir_pkg::value_t   out_head_value
);
  import stir_pkg::*;

  logic     cmd_r;
  value_t   val_r;
  value_t   cell_r   [CAPACITY];
  value_t   cell_nxt [CAPACITY];
  cnt_t     count_r, count_nxt;
  status_t  status_nxt;
  status_t  status_r;
  out_cnt_t ocount_r;
  value_t   head_r, head_nxt;

  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] keep_lt;
  logic [CAPACITY-1:0] match;
  logic full, found, do_ins, do_rem, wr_en;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid[i]   = cnt_t'(i) < count_r;
    assign keep_lt[i] = valid[i] && (cell_r[i] < val_r);
    assign match[i]   = valid[i] && (cell_r[i] == val_r);

    value_t ins_v, rem_v;
    if (i == 0) begin : g_first
      assign ins_v = keep_lt[i] ? cell_r[i] : val_r;
    end else begin : g_rest
      assign ins_v = keep_lt[i] ? cell_r[i] : (keep_lt[i-1] ? val_r : cell_r[i-1]);
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rem_v = cell_r[i];
    end else begin : g_mid
      assign rem_v = keep_lt[i] ? cell_r[i] : cell_r[i+1];
    end

    assign cell_nxt[i] = do_ins ? ins_v : (do_rem ? rem_v : cell_r[i]);

    always_ff @(posedge clk) begin
      if (wr_en) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
  end

  assign full   = (count_r == cnt_t'(CAPACITY));
  assign found  = |match;
  assign do_ins = (cmd_r == CMD_INSERT) && !full;
  assign do_rem = (cmd_r == CMD_REMOVE) && found;
  assign wr_en  = ctl.exec && (do_ins || do_rem);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (cmd_r == CMD_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + cnt_t'(1);
      end
    end else begin
      if (found) begin
        count_nxt = count_r - cnt_t'(1);
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end
    head_nxt = (count_nxt != '0) ? cell_nxt[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
    end
    if (ctl.exec) begin
      status_r <= status_nxt;
      ocount_r <= out_cnt_t'(count_nxt);
      head_r   <= head_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_count      = ocount_r;
  assign out_head_value = head_r;

endmodule

[bench/tb_sorted_table_insert_remove_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_remove_core
// Drives insert and remove commands into the sorted table core and checks
// every result beat (status, count, smallest value) against a table that the
// bench keeps in step with each accepted command. Directed extremes and a
// full-table pass come first, then random traffic under three idle patterns.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_remove_core;
  import stir_pkg::*;

  localparam int     STALL_LIMIT = 4000;
  localparam int     MAX_REPORTS = 10;
  localparam value_t VAL_MAX     = 32'h7FFF_FFFF;
  localparam value_t VAL_MIN     = 32'h8000_0000;

  typedef struct packed {
    status_t  status;
    out_cnt_t count;
    value_t   head;
  } table_result_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  logic      in_cmd = CMD_INSERT;
  value_t    in_value = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  status_t   out_status;
  out_cnt_t  out_count;
  value_t    out_head_value;

  value_t        shadow [CAPACITY];
  int            held = 0;
  table_result_t pending_results [$];
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            rcv_idle_pct = 0;
  int            quiet_cycles = 0;

  sorted_table_insert_remove_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_head_value (out_head_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic table_result_t apply_table_op(logic cmd, value_t v);
    table_result_t r;
    int pos;
    pos = 0;
    if (cmd == CMD_INSERT) begin
      if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        while (pos < held && shadow[pos] < v) pos++;
        for (int i = held; i > pos; i--) shadow[i] = shadow[i-1];
        shadow[pos] = v;
        held++;
        r.status = ST_DONE;
      end
    end else begin
      while (pos < held && shadow[pos] != v) pos++;
      if (pos >= held) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < held; i++) shadow[i] = shadow[i+1];
        held--;
        r.status = ST_DONE;
      end
    end
    r.count = out_cnt_t'(held);
    r.head  = (held > 0) ? shadow[0] : '0;
    return r;
  endfunction

  task automatic send_beat(logic cmd, value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_table_op(cmd, v));
  endtask

  // receiver side: random back-pressure and result compare
  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result beat: status %0d count %0d head %0d",
                     out_status, out_count, out_head_value);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_status !== exp_r.status || out_count !== exp_r.count ||
              out_head_value !== exp_r.head) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result mismatch: exp status %0d count %0d head %0d, got %0d %0d %0d",
                       exp_r.status, exp_r.count, exp_r.head,
                       out_status, out_count, out_head_value);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic test_extremes;
    send_beat(CMD_REMOVE, 32'sd0);
    send_beat(CMD_INSERT, VAL_MAX);
    send_beat(CMD_INSERT, VAL_MIN);
    send_beat(CMD_INSERT, 32'sd0);
    send_beat(CMD_INSERT, -32'sd1);
    send_beat(CMD_INSERT, VAL_MIN);
    send_beat(CMD_REMOVE, VAL_MIN);
    send_beat(CMD_REMOVE, 32'sd5);
    send_beat(CMD_REMOVE, VAL_MAX);
    send_beat(CMD_REMOVE, 32'sd0);
  endtask

  task automatic test_full_table;
    while (held < CAPACITY) send_beat(CMD_INSERT, value_t'($urandom));
    send_beat(CMD_INSERT, VAL_MAX);
    send_beat(CMD_INSERT, VAL_MIN);
    send_beat(CMD_REMOVE, value_t'($urandom));
  endtask

  task automatic test_random_mix(int snd_pct, int rcv_pct, int n_items);
    int     insert_pct;
    int     roll;
    logic   cmd;
    value_t v;
    send_idle_pct = snd_pct;
    rcv_idle_pct  = rcv_pct;
    insert_pct    = 75;
    for (int k = 0; k < n_items; k++) begin
      // every 40 items, drift toward full or toward empty at random
      if (k % 40 == 0) insert_pct = ($urandom_range(1) != 0) ? 75 : 25;
      cmd  = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      roll = $urandom_range(99);
      if (cmd == CMD_REMOVE && held > 0 && roll < 75)
        v = shadow[$urandom_range(held - 1)];
      else if (roll < 30)
        v = value_t'($signed($urandom_range(8)) - 4);
      else if (roll < 40)
        v = ($urandom_range(1) != 0) ? VAL_MAX : VAL_MIN;
      else if (roll < 50 && held > 0)
        v = shadow[$urandom_range(held - 1)];
      else
        v = value_t'($urandom);
      send_beat(cmd, v);
    end
  endtask

  initial begin
    int drain;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_full_table();
    test_random_mix(22, 84, 450);
    test_random_mix(84, 22, 450);
    test_random_mix(0, 0, 450);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 10) begin
      @(posedge clk);
      drain++;
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
